// ----- rtl/multi_turtle_grid_plotter_defines.svh -----
// Assertion macros used by the top level of the turtle grid plotter RTL.
`ifndef MULTI_TURTLE_GRID_PLOTTER_DEFINES_SVH
`define MULTI_TURTLE_GRID_PLOTTER_DEFINES_SVH

// Condition and consequence checked on the same clock edge.
`define MTGP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequence checked in the cycle after the condition.
`define MTGP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/mtgp_pkg.sv -----
// Package with the shared types and codes of the turtle grid plotter.
`default_nettype none

package mtgp_pkg;

  // Input command codes as they arrive on the kind port.
  localparam logic [2:0] KIND_MOVE  = 3'd0;
  localparam logic [2:0] KIND_MARK  = 3'd1;
  localparam logic [2:0] KIND_LEFT  = 3'd2;
  localparam logic [2:0] KIND_RIGHT = 3'd3;
  localparam logic [2:0] KIND_ADD   = 3'd4;
  localparam logic [2:0] KIND_READ  = 3'd5;
  localparam logic [2:0] KIND_CLEAR = 3'd6;

  // Configuration register indexes.
  localparam logic REG_GRID_ROWS = 1'b0;
  localparam logic REG_GRID_COLS = 1'b1;

  // Headings, rotated anticlockwise by a left turn.
  localparam logic [1:0] HEAD_EAST  = 2'd0;
  localparam logic [1:0] HEAD_NORTH = 2'd1;
  localparam logic [1:0] HEAD_WEST  = 2'd2;
  localparam logic [1:0] HEAD_SOUTH = 2'd3;

  // Command queue geometry.
  localparam int QDEPTH = 2;
  localparam int QPW    = 1;

  // Operations carried from the front end to the executor.
  typedef enum logic [2:0] {
    OP_MOVE,
    OP_MARK,
    OP_LEFT,
    OP_RIGHT,
    OP_ADD,
    OP_READ,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [5:0] qrow;
    logic [5:0] qcol;
  } cmd_t;

  // Front end to queue.
  typedef struct packed {
    logic push;
    cmd_t cmd;
  } qwr_t;

  // Queue to executor and front end.
  typedef struct packed {
    logic valid;
    logic full;
    cmd_t cmd;
  } qrd_t;

  // Executor sequencer states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_MARK,
    ST_READ,
    ST_CLEAR
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/mtgp_front.sv -----
// Front end: accepts commands, decodes the kind and pushes work into the queue.
`default_nettype none

module mtgp_front (
  input  logic              start,
  input  logic [2:0]        kind,
  input  logic [5:0]        query_row,
  input  logic [5:0]        query_col,
  input  mtgp_pkg::qrd_t    qrd,
  input  logic              init_busy,
  output logic              busy,
  output mtgp_pkg::qwr_t    qwr
);
  import mtgp_pkg::*;

  logic accept;

  // Hold off new commands while the queue is full or the canvas is being initialised.
  assign busy   = qrd.full | init_busy;
  assign accept = start & ~busy;

  // Decode the kind; the unused code is accepted and dropped.
  always_comb begin
    qwr.push     = 1'b0;
    qwr.cmd.op   = OP_MOVE;
    qwr.cmd.qrow = query_row;
    qwr.cmd.qcol = query_col;
    case (kind)
      KIND_MOVE: begin
        qwr.push   = accept;
        qwr.cmd.op = OP_MOVE;
      end
      KIND_MARK: begin
        qwr.push   = accept;
        qwr.cmd.op = OP_MARK;
      end
      KIND_LEFT: begin
        qwr.push   = accept;
        qwr.cmd.op = OP_LEFT;
      end
      KIND_RIGHT: begin
        qwr.push   = accept;
        qwr.cmd.op = OP_RIGHT;
      end
      KIND_ADD: begin
        qwr.push   = accept;
        qwr.cmd.op = OP_ADD;
      end
      KIND_READ: begin
        qwr.push   = accept;
        qwr.cmd.op = OP_READ;
      end
      KIND_CLEAR: begin
        qwr.push   = accept;
        qwr.cmd.op = OP_CLEAR;
      end
      default: begin
        qwr.push = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/mtgp_queue.sv -----
// Two-entry command queue between the front end and the executor.
`default_nettype none

module mtgp_queue (
  input  logic           clk,
  input  logic           rst,
  input  mtgp_pkg::qwr_t qwr,
  input  logic           pop,
  output mtgp_pkg::qrd_t qrd
);
  import mtgp_pkg::*;

  cmd_t           slots [QDEPTH];
  logic [QPW-1:0] wptr;
  logic [QPW-1:0] rptr;
  logic [QPW:0]   count;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (qwr.push) begin
        wptr <= wptr + QPW'(1);
      end
      if (pop) begin
        rptr <= rptr + QPW'(1);
      end
      count <= count + (QPW+1)'(qwr.push) - (QPW+1)'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (qwr.push) begin
      slots[wptr] <= qwr.cmd;
    end
  end

  assign qrd.valid = (count != '0);
  assign qrd.full  = (count == (QPW+1)'(QDEPTH));
  assign qrd.cmd   = slots[rptr];

endmodule

`default_nettype wire

// ----- rtl/mtgp_exec.sv -----
// Executor: turtle state, canvas memory and the sequencer that carries out commands.
`default_nettype none

module mtgp_exec #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64,
  parameter int TURTLES  = 3
) (
  input  logic                           clk,
  input  logic                           rst,
  input  mtgp_pkg::qrd_t                 qrd,
  input  logic [$clog2(MAX_ROWS+1)-1:0]  rows_size,
  input  logic [$clog2(MAX_COLS+1)-1:0]  cols_size,
  output logic                           pop,
  output logic                           init_busy,
  output logic                           result_strobe,
  output logic [1:0]                     turtle_index,
  output logic [5:0]                     pos_row,
  output logic [5:0]                     pos_col,
  output logic                           cell_marked,
  output logic                           last
);
  import mtgp_pkg::*;

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RSW   = $clog2(MAX_ROWS + 1);
  localparam int CSW   = $clog2(MAX_COLS + 1);
  localparam int RPW   = (RW + 1 > RSW) ? RW + 1 : RSW;
  localparam int CPW   = (CW + 1 > CSW) ? CW + 1 : CSW;
  localparam int QRW   = (RSW > 6) ? RSW : 6;
  localparam int QCW   = (CSW > 6) ? CSW : 6;
  localparam int TIW   = (TURTLES > 1) ? $clog2(TURTLES) : 1;
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  state_t          state;
  state_t          state_next;
  logic [TIW-1:0]  idx;
  logic [TIW-1:0]  idx_next;
  logic [AW-1:0]   clr_addr;
  logic [AW-1:0]   clr_addr_next;
  logic [TIW-1:0]  active_count;

  logic [RW-1:0]   turtle_row     [TURTLES];
  logic [CW-1:0]   turtle_col     [TURTLES];
  logic [1:0]      turtle_heading [TURTLES];
  logic [RW-1:0]   row_up         [TURTLES];
  logic [RW-1:0]   row_dn         [TURTLES];
  logic [CW-1:0]   col_up         [TURTLES];
  logic [CW-1:0]   col_dn         [TURTLES];

  logic            canvas_mem [CELLS];
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic            mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic            mem_rdata;

  logic            do_move;
  logic            do_left;
  logic            do_right;
  logic            do_add;
  logic            rd_latch;
  logic            rd_hit;
  logic            rd_hit_next;
  logic [5:0]      rd_qrow;
  logic [5:0]      rd_qcol;

  logic            res_strobe_next;
  logic [1:0]      res_index_next;
  logic [5:0]      res_row_next;
  logic [5:0]      res_col_next;
  logic            res_marked_next;
  logic            res_last_next;

  logic [RW-1:0]   sel_row;
  logic [CW-1:0]   sel_col;

  assign init_busy = (state == ST_INIT);
  assign sel_row   = turtle_row[idx];
  assign sel_col   = turtle_col[idx];

  // Wrapped neighbour positions of every turtle, one lane each.
  always_comb begin
    for (int t = 0; t < TURTLES; t++) begin
      row_up[t] = (RPW'(turtle_row[t]) + RPW'(1) >= RPW'(rows_size)) ?
                  '0 : turtle_row[t] + RW'(1);
      row_dn[t] = (turtle_row[t] == '0) ? RW'(rows_size - RSW'(1)) :
                  turtle_row[t] - RW'(1);
      col_up[t] = (CPW'(turtle_col[t]) + CPW'(1) >= CPW'(cols_size)) ?
                  '0 : turtle_col[t] + CW'(1);
      col_dn[t] = (turtle_col[t] == '0) ? CW'(cols_size - CSW'(1)) :
                  turtle_col[t] - CW'(1);
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      idx      <= '0;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      idx      <= idx_next;
      clr_addr <= clr_addr_next;
    end
  end

  // Next state, memory controls and result values.
  always_comb begin
    state_next      = state;
    idx_next        = idx;
    clr_addr_next   = clr_addr;
    pop             = 1'b0;
    do_move         = 1'b0;
    do_left         = 1'b0;
    do_right        = 1'b0;
    do_add          = 1'b0;
    rd_latch        = 1'b0;
    rd_hit_next     = (QRW'(qrd.cmd.qrow) < QRW'(MAX_ROWS)) &&
                      (QCW'(qrd.cmd.qcol) < QCW'(MAX_COLS));
    mem_we          = 1'b0;
    mem_waddr       = clr_addr;
    mem_wdata       = 1'b0;
    mem_re          = 1'b0;
    mem_raddr       = AW'(AW'(qrd.cmd.qrow) * AW'(MAX_COLS)) + AW'(qrd.cmd.qcol);
    res_strobe_next = 1'b0;
    res_index_next  = 2'(idx);
    res_row_next    = 6'(sel_row);
    res_col_next    = 6'(sel_col);
    res_marked_next = 1'b1;
    res_last_next   = (idx == active_count);
    case (state)
      ST_INIT, ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr == AW'(CELLS - 1)) begin
          clr_addr_next = '0;
          state_next    = ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + AW'(1);
        end
      end
      ST_IDLE: begin
        if (qrd.valid) begin
          pop = 1'b1;
          case (qrd.cmd.op)
            OP_MOVE:  do_move = 1'b1;
            OP_LEFT:  do_left = 1'b1;
            OP_RIGHT: do_right = 1'b1;
            OP_ADD:   do_add = 1'b1;
            OP_MARK: begin
              idx_next   = '0;
              state_next = ST_MARK;
            end
            OP_READ: begin
              mem_re     = 1'b1;
              rd_latch   = 1'b1;
              state_next = ST_READ;
            end
            OP_CLEAR: begin
              clr_addr_next = '0;
              state_next    = ST_CLEAR;
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      ST_MARK: begin
        // One turtle a cycle through the single write port.
        mem_we          = 1'b1;
        mem_waddr       = AW'(AW'(sel_row) * AW'(MAX_COLS)) + AW'(sel_col);
        mem_wdata       = 1'b1;
        res_strobe_next = 1'b1;
        if (idx == active_count) begin
          idx_next   = '0;
          state_next = ST_IDLE;
        end else begin
          idx_next = idx + TIW'(1);
        end
      end
      ST_READ: begin
        res_strobe_next = 1'b1;
        res_index_next  = 2'd0;
        res_row_next    = rd_qrow;
        res_col_next    = rd_qcol;
        res_marked_next = rd_hit & mem_rdata;
        res_last_next   = 1'b1;
        state_next      = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Turtle positions, headings and the active count.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < TURTLES; t++) begin
        turtle_row[t]     <= '0;
        turtle_col[t]     <= '0;
        turtle_heading[t] <= HEAD_EAST;
      end
      active_count <= '0;
    end else begin
      for (int t = 0; t < TURTLES; t++) begin
        if (t <= int'(active_count)) begin
          if (do_move) begin
            case (turtle_heading[t])
              HEAD_EAST:  turtle_col[t] <= col_up[t];
              HEAD_NORTH: turtle_row[t] <= row_dn[t];
              HEAD_WEST:  turtle_col[t] <= col_dn[t];
              default:    turtle_row[t] <= row_up[t];
            endcase
          end
          if (do_left) begin
            turtle_heading[t] <= turtle_heading[t] + 2'd1;
          end
          if (do_right) begin
            turtle_heading[t] <= turtle_heading[t] + 2'd3;
          end
        end
      end
      if (do_add && (active_count < TIW'(TURTLES - 1))) begin
        active_count <= active_count + TIW'(1);
      end
    end
  end

  // Canvas memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      canvas_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_rdata <= canvas_mem[mem_raddr];
    end
  end

  // Query held for the read result.
  always_ff @(posedge clk) begin
    if (rd_latch) begin
      rd_hit  <= rd_hit_next;
      rd_qrow <= qrd.cmd.qrow;
      rd_qcol <= qrd.cmd.qcol;
    end
  end

  // Result register: strobe under reset, payload without.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= res_strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    turtle_index <= res_index_next;
    pos_row      <= res_row_next;
    pos_col      <= res_col_next;
    cell_marked  <= res_marked_next;
    last         <= res_last_next;
  end

endmodule

`default_nettype wire

// ----- rtl/multi_turtle_grid_plotter.sv -----
// Top level of the multi-turtle grid plotter: configuration registers and block wiring.
`default_nettype none
`include "multi_turtle_grid_plotter_defines.svh"

// A command is taken when start is high and busy is low; results appear one per
// cycle on result_strobe and cannot be held off. After reset the canvas is swept
// clear, one cell a cycle, while busy stays high. A two-entry queue separates
// command intake from execution; the executor carries out a move, turn or add
// straight from its idle state, writes one cell a cycle for a mark (one canvas
// write port, one cell per active turtle), reads the canvas through a registered
// memory read before reporting, and sweeps every cell of the canvas on a clear.

module multi_turtle_grid_plotter #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64,
  parameter int TURTLES  = 3
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] kind,
  input  logic [5:0] query_row,
  input  logic [5:0] query_col,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data,
  output logic       result_strobe,
  output logic [1:0] turtle_index,
  output logic [5:0] pos_row,
  output logic [5:0] pos_col,
  output logic       cell_marked,
  output logic       last
);
  import mtgp_pkg::*;

  localparam int RSW      = $clog2(MAX_ROWS + 1);
  localparam int CSW      = $clog2(MAX_COLS + 1);
  localparam int RCW      = (RSW > 7) ? RSW : 7;
  localparam int CCW      = (CSW > 7) ? CSW : 7;
  localparam int RST_ROWS = (MAX_ROWS < 64) ? MAX_ROWS : 64;
  localparam int RST_COLS = (MAX_COLS < 64) ? MAX_COLS : 64;

  logic [RSW-1:0] rows_size;
  logic [CSW-1:0] cols_size;
  logic [RSW-1:0] rows_clamped;
  logic [CSW-1:0] cols_clamped;
  logic [RCW-1:0] rows_wide;
  logic [CCW-1:0] cols_wide;
  logic           init_busy;
  logic           pop;
  qwr_t           q_wr;
  qrd_t           q_rd;

  // Grid sizes are kept already clamped to the range the wrap logic expects.
  assign rows_wide = RCW'(cfg_data);
  assign cols_wide = CCW'(cfg_data);

  always_comb begin
    if (rows_wide == '0) begin
      rows_clamped = RSW'(1);
    end else if (rows_wide > RCW'(MAX_ROWS)) begin
      rows_clamped = RSW'(MAX_ROWS);
    end else begin
      rows_clamped = RSW'(rows_wide);
    end
    if (cols_wide == '0) begin
      cols_clamped = CSW'(1);
    end else if (cols_wide > CCW'(MAX_COLS)) begin
      cols_clamped = CSW'(MAX_COLS);
    end else begin
      cols_clamped = CSW'(cols_wide);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_size <= RSW'(RST_ROWS);
      cols_size <= CSW'(RST_COLS);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_ROWS: rows_size <= rows_clamped;
        REG_GRID_COLS: cols_size <= cols_clamped;
        default: begin
          rows_size <= rows_size;
        end
      endcase
    end
  end

  // Command intake.
  mtgp_front u_front (
    .start     (start),
    .kind      (kind),
    .query_row (query_row),
    .query_col (query_col),
    .qrd       (q_rd),
    .init_busy (init_busy),
    .busy      (busy),
    .qwr       (q_wr)
  );

  // Queue between intake and execution.
  mtgp_queue u_queue (
    .clk (clk),
    .rst (rst),
    .qwr (q_wr),
    .pop (pop),
    .qrd (q_rd)
  );

  // Command execution and canvas.
  mtgp_exec #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .TURTLES  (TURTLES)
  ) u_exec (
    .clk           (clk),
    .rst           (rst),
    .qrd           (q_rd),
    .rows_size     (rows_size),
    .cols_size     (cols_size),
    .pop           (pop),
    .init_busy     (init_busy),
    .result_strobe (result_strobe),
    .turtle_index  (turtle_index),
    .pos_row       (pos_row),
    .pos_col       (pos_col),
    .cell_marked   (cell_marked),
    .last          (last)
  );

  // A push never lands on a full queue.
  `MTGP_ASSERT_SAME(a_push_room, q_wr.push, !q_rd.full, "push into a full command queue")
  // The canvas sweep after reset keeps the block closed to commands.
  `MTGP_ASSERT_SAME(a_init_busy, init_busy, busy, "command port open during initial sweep")
  // A mark report that is not the last is followed straight away by the next one.
  `MTGP_ASSERT_NEXT(a_mark_burst, result_strobe && !last, result_strobe, "mark burst broken")
  // The final result of a transaction is never directly followed by another result.
  `MTGP_ASSERT_NEXT(a_gap_after_last, result_strobe && last, !result_strobe,
    "result directly after final result")

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for the multi-turtle grid plotter: directed script, then random phases.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mtgp_pkg::*;

  localparam int GRID_MAX_ROWS = 64;
  localparam int GRID_MAX_COLS = 64;
  localparam int TURTLE_SLOTS  = 3;
  localparam int CANVAS_CELLS  = GRID_MAX_ROWS * GRID_MAX_COLS;
  // A running clear and two queued ones can keep the block working this long after the
  // last report.
  localparam int DRAIN_CYCLES  = 3 * (1 + CANVAS_CELLS) + 16;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 56;
  localparam int SCRIPT_ROWS   = 25;
  localparam int PRINT_CAP     = 40;

  // Code outside the defined command set; the block must ignore it.
  localparam logic [2:0] KIND_UNUSED = 3'd7;

  typedef struct packed {
    logic [1:0] idx;
    logic [5:0] row;
    logic [5:0] col;
    logic       marked;
    logic       last;
  } plot_report_t;

  typedef struct packed {
    logic [2:0]   k;
    logic [5:0]   qr;
    logic [5:0]   qc;
    logic         typed;
    plot_report_t want;
  } script_row_t;

  localparam plot_report_t NO_REPORT = '0;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] kind = KIND_MOVE;
  logic [5:0] query_row = '0;
  logic [5:0] query_col = '0;
  logic       cfg_we = 1'b0;
  logic       cfg_index = REG_GRID_ROWS;
  logic [6:0] cfg_data = '0;
  logic       result_strobe;
  logic [1:0] turtle_index;
  logic [5:0] pos_row;
  logic [5:0] pos_col;
  logic       cell_marked;
  logic       last;

  multi_turtle_grid_plotter #(
    .MAX_ROWS(GRID_MAX_ROWS),
    .MAX_COLS(GRID_MAX_COLS),
    .TURTLES(TURTLE_SLOTS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .query_row(query_row),
    .query_col(query_col),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .result_strobe(result_strobe),
    .turtle_index(turtle_index),
    .pos_row(pos_row),
    .pos_col(pos_col),
    .cell_marked(cell_marked),
    .last(last)
  );

  // Shadow of the plotter state, updated as each transaction is accepted.
  bit           canvas_bits [CANVAS_CELLS];
  logic [5:0]   trow [TURTLE_SLOTS];
  logic [5:0]   tcol [TURTLE_SLOTS];
  logic [1:0]   thead [TURTLE_SLOTS];
  int unsigned  extra_turtles;
  logic [6:0]   rows_reg;
  logic [6:0]   cols_reg;

  plot_report_t step_reports [$];
  plot_report_t pending_reports [$];

  int unsigned  mismatches;
  int unsigned  reports_checked;
  int unsigned  kind_count [8];
  int unsigned  burst_left;

  // Hand-checked opening script; rows without a typed report rely on the shadow model.
  script_row_t directed_script [SCRIPT_ROWS] = '{
    '{KIND_READ,   6'd0,  6'd0,  1'b1, '{2'd0, 6'd0,  6'd0,  1'b0, 1'b1}},
    '{KIND_READ,   6'd63, 6'd63, 1'b1, '{2'd0, 6'd63, 6'd63, 1'b0, 1'b1}},
    '{KIND_MARK,   6'd0,  6'd0,  1'b1, '{2'd0, 6'd0,  6'd0,  1'b1, 1'b1}},
    '{KIND_READ,   6'd0,  6'd0,  1'b1, '{2'd0, 6'd0,  6'd0,  1'b1, 1'b1}},
    '{KIND_MOVE,   6'd0,  6'd0,  1'b0, NO_REPORT},
    '{KIND_LEFT,   6'd0,  6'd0,  1'b0, NO_REPORT},
    '{KIND_MOVE,   6'd0,  6'd0,  1'b0, NO_REPORT},
    '{KIND_MARK,   6'd0,  6'd0,  1'b0, NO_REPORT},
    '{KIND_READ,   6'd63, 6'd1,  1'b0, NO_REPORT},
    '{KIND_ADD,    6'd0,  6'd0,  1'b0, NO_REPORT},
    '{KIND_ADD,    6'd0,  6'd0,  1'b0, NO_REPORT},
    '{KIND_ADD,    6'd0,  6'd0,  1'b0, NO_REPORT},
    '{KIND_ADD,    6'd0,  6'd0,  1'b0, NO_REPORT},
    '{KIND_MARK,   6'd0,  6'd0,  1'b0, NO_REPORT},
    '{KIND_RIGHT,  6'd0,  6'd0,  1'b0, NO_REPORT},
    '{KIND_RIGHT,  6'd0,  6'd0,  1'b0, NO_REPORT},
    '{KIND_MOVE,   6'd0,  6'd0,  1'b0, NO_REPORT},
    '{KIND_MARK,   6'd0,  6'd0,  1'b0, NO_REPORT},
    '{KIND_UNUSED, 6'd42, 6'd21, 1'b0, NO_REPORT},
    '{KIND_READ,   6'd42, 6'd21, 1'b1, '{2'd0, 6'd42, 6'd21, 1'b0, 1'b1}},
    '{KIND_CLEAR,  6'd0,  6'd0,  1'b0, NO_REPORT},
    '{KIND_READ,   6'd63, 6'd1,  1'b1, '{2'd0, 6'd63, 6'd1,  1'b0, 1'b1}},
    '{KIND_READ,   6'd21, 6'd42, 1'b1, '{2'd0, 6'd21, 6'd42, 1'b0, 1'b1}},
    '{KIND_MARK,   6'd0,  6'd0,  1'b0, NO_REPORT},
    '{KIND_READ,   6'd0,  6'd63, 1'b0, NO_REPORT}
  };

  // Grid settings per random phase; the last one is drawn at run time.
  logic [6:0] phase_rows [PHASES] = '{7'd0, 7'd1, 7'd3, 7'd127, 7'd64, 7'd7, 7'd2, 7'd0};
  logic [6:0] phase_cols [PHASES] = '{7'd0, 7'd1, 7'd5, 7'd127, 7'd1, 7'd64, 7'd3, 7'd0};

  // Free-running clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Register value as the block uses it: zero counts as one, large values saturate.
  function automatic int unsigned used_size(input logic [6:0] reg_val, input int unsigned limit);
    if (reg_val == 0) return 1;
    if (reg_val > limit) return limit;
    return reg_val;
  endfunction

  // Forward step wraps to zero once it passes the last row or column in use.
  function automatic logic [5:0] step_fwd(input logic [5:0] p, input int unsigned size);
    int unsigned nxt;
    nxt = p + 1;
    return (nxt > size - 1) ? 6'd0 : 6'(nxt);
  endfunction

  // Backward step from zero wraps to the last row or column in use.
  function automatic logic [5:0] step_back(input logic [5:0] p, input int unsigned size);
    return (p == 0) ? 6'(size - 1) : p - 6'd1;
  endfunction

  function automatic int unsigned live_turtles();
    return (extra_turtles + 1 > TURTLE_SLOTS) ? TURTLE_SLOTS : extra_turtles + 1;
  endfunction

  // Advances the shadow state by one command and lists the reports it causes.
  function automatic void plot_step(input logic [2:0] k, input logic [5:0] qr,
                                    input logic [5:0] qc);
    int unsigned  rows;
    int unsigned  cols;
    int unsigned  n;
    plot_report_t rep;
    rows = used_size(rows_reg, GRID_MAX_ROWS);
    cols = used_size(cols_reg, GRID_MAX_COLS);
    n = live_turtles();
    step_reports.delete();
    case (k)
      KIND_MOVE: begin
        for (int i = 0; i < n; i++) begin
          case (thead[i])
            HEAD_EAST:  tcol[i] = step_fwd(tcol[i], cols);
            HEAD_NORTH: trow[i] = step_back(trow[i], rows);
            HEAD_WEST:  tcol[i] = step_back(tcol[i], cols);
            default:    trow[i] = step_fwd(trow[i], rows);
          endcase
        end
      end
      KIND_MARK: begin
        for (int i = 0; i < n; i++) begin
          canvas_bits[int'(trow[i]) * GRID_MAX_COLS + int'(tcol[i])] = 1'b1;
          rep.idx = 2'(i);
          rep.row = trow[i];
          rep.col = tcol[i];
          rep.marked = 1'b1;
          rep.last = (i + 1 == n);
          step_reports.push_back(rep);
        end
      end
      KIND_LEFT: begin
        for (int i = 0; i < n; i++) thead[i] = thead[i] + 2'd1;
      end
      KIND_RIGHT: begin
        for (int i = 0; i < n; i++) thead[i] = thead[i] - 2'd1;
      end
      KIND_ADD: begin
        if (extra_turtles + 1 < TURTLE_SLOTS) extra_turtles++;
      end
      KIND_READ: begin
        rep.idx = 2'd0;
        rep.row = qr;
        rep.col = qc;
        rep.marked = canvas_bits[int'(qr) * GRID_MAX_COLS + int'(qc)];
        rep.last = 1'b1;
        step_reports.push_back(rep);
      end
      KIND_CLEAR: begin
        foreach (canvas_bits[j]) canvas_bits[j] = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // One line per mismatch, with printing capped so a broken block cannot flood the log.
  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_CAP) $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Sender works in bursts; between bursts start drops for a random gap, sometimes none.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Offers one command and records its expected reports once the transaction is taken.
  task automatic issue_cmd(input logic [2:0] k, input logic [5:0] qr, input logic [5:0] qc,
                           input logic typed, input plot_report_t typed_rep);
    pace_sender();
    start <= 1'b1;
    kind <= k;
    query_row <= qr;
    query_col <= qc;
    do @(posedge clk); while (busy);
    plot_step(k, qr, qc);
    if (typed) begin
      step_reports.delete();
      step_reports.push_back(typed_rep);
    end
    foreach (step_reports[j]) pending_reports.push_back(step_reports[j]);
    kind_count[k]++;
  endtask

  // Lets every outstanding report arrive, then waits out any silent work still queued.
  task automatic drain_block();
    start <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes both grid registers while the block is idle.
  task automatic write_grid(input logic [6:0] r, input logic [6:0] c);
    drain_block();
    cfg_we <= 1'b1;
    cfg_index <= REG_GRID_ROWS;
    cfg_data <= r;
    @(posedge clk);
    cfg_index <= REG_GRID_COLS;
    cfg_data <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    rows_reg = r;
    cols_reg = c;
  endtask

  // Random command mix, weighted towards moves, marks and reads.
  function automatic logic [2:0] pick_kind();
    int unsigned w;
    w = $urandom_range(0, 99);
    if (w < 30) return KIND_MOVE;
    if (w < 50) return KIND_MARK;
    if (w < 58) return KIND_LEFT;
    if (w < 66) return KIND_RIGHT;
    if (w < 71) return KIND_ADD;
    if (w < 95) return KIND_READ;
    if (w < 97) return KIND_CLEAR;
    return KIND_UNUSED;
  endfunction

  // Report checker: every strobed report is matched against the oldest expectation.
  always @(posedge clk) begin
    plot_report_t want;
    if (!rst && result_strobe) begin
      if (pending_reports.size() == 0) begin
        report_mismatch($sformatf("report (%0d,%0d) turtle %0d with none outstanding",
                                  pos_row, pos_col, turtle_index));
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (turtle_index !== want.idx)
          report_mismatch($sformatf("turtle_index %0d, expected %0d", turtle_index, want.idx));
        if (pos_row !== want.row)
          report_mismatch($sformatf("pos_row %0d, expected %0d", pos_row, want.row));
        if (pos_col !== want.col)
          report_mismatch($sformatf("pos_col %0d, expected %0d", pos_col, want.col));
        if (cell_marked !== want.marked)
          report_mismatch($sformatf("cell_marked %0b, expected %0b at (%0d,%0d)",
                                    cell_marked, want.marked, want.row, want.col));
        if (last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
      end
    end
  end

  // Main sequence: reset, directed script, then random phases over several grid sizes.
  initial begin
    logic [2:0]  k;
    logic [5:0]  qr;
    logic [5:0]  qc;
    int unsigned pick;
    foreach (canvas_bits[j]) canvas_bits[j] = 1'b0;
    foreach (trow[i]) begin
      trow[i] = '0;
      tcol[i] = '0;
      thead[i] = HEAD_EAST;
    end
    extra_turtles = 0;
    rows_reg = 7'd64;
    cols_reg = 7'd64;
    mismatches = 0;
    reports_checked = 0;
    burst_left = 0;
    foreach (kind_count[j]) kind_count[j] = 0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_script[r])
      issue_cmd(directed_script[r].k, directed_script[r].qr, directed_script[r].qc,
                directed_script[r].typed, directed_script[r].want);

    phase_rows[PHASES - 1] = 7'($urandom_range(1, 127));
    phase_cols[PHASES - 1] = 7'($urandom_range(1, 127));
    for (int p = 0; p < PHASES; p++) begin
      write_grid(phase_rows[p], phase_cols[p]);
      for (int it = 0; it < PHASE_ITEMS; it++) begin
        // Hold off mid-phase now and then until the block has reported everything.
        if (it == PHASE_ITEMS / 2 && (p % 3) == 2) begin
          start <= 1'b0;
          do @(posedge clk); while (pending_reports.size() != 0);
        end
        k = pick_kind();
        qr = 6'($urandom_range(0, 63));
        qc = 6'($urandom_range(0, 63));
        // Most reads look under a turtle so that marked cells are read back.
        if (k == KIND_READ && $urandom_range(0, 9) < 6) begin
          pick = $urandom_range(0, live_turtles() - 1);
          qr = trow[pick];
          qc = tcol[pick];
        end
        issue_cmd(k, qr, qc, 1'b0, NO_REPORT);
      end
    end

    drain_block();
    $display("Ran %0d grid settings: %0d moves, %0d marks, %0d turns, %0d adds,",
             PHASES + 1, kind_count[KIND_MOVE], kind_count[KIND_MARK],
             kind_count[KIND_LEFT] + kind_count[KIND_RIGHT], kind_count[KIND_ADD]);
    $display("%0d reads, %0d clears, %0d unused codes; %0d reports checked, %0d mismatches.",
             kind_count[KIND_READ], kind_count[KIND_CLEAR], kind_count[KIND_UNUSED],
             reports_checked, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog for a hung block.
  initial begin
    #10_000_000;
    $display("Timed out with %0d reports outstanding.", pending_reports.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/mtgp_pkg.sv
rtl/mtgp_front.sv
rtl/mtgp_queue.sv
rtl/mtgp_exec.sv
rtl/multi_turtle_grid_plotter.sv
test/tb_top.sv
